>>> rtl/qmn_pkg.sv
// Package for the normalized quaternion product block.
// Holds the Hamilton product term table and the side-band struct of the pipeline.
// No dependencies.
package qmn_pkg;

	typedef logic [1:0] idx_t;

	// Component index of a, of b, and the negate mark, for each term of each product component.
	parameter idx_t TERM_A [4][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd0, 2'd1, 2'd2, 2'd3}
	};
	parameter idx_t TERM_B [4][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd1, 2'd0, 2'd3, 2'd2},
		'{2'd2, 2'd3, 2'd0, 2'd1},
		'{2'd3, 2'd2, 2'd1, 2'd0}
	};
	parameter logic TERM_NEG [4][4] = '{
		'{1'b0, 1'b1, 1'b1, 1'b1},
		'{1'b0, 1'b0, 1'b0, 1'b1},
		'{1'b0, 1'b1, 1'b0, 1'b0},
		'{1'b0, 1'b0, 1'b1, 1'b0}
	};

	// Side-band information that travels with each transaction down the pipeline.
	typedef struct packed {
		logic       vld;
		logic [3:0] neg;
		logic       zero;
	} side_t;

endpackage

>>> rtl/qmn_in_if.sv
// Operand channel of the normalized quaternion product block.
// Carries valid, ready and the two input quaternions; no dependencies.
interface qmn_in_if #(parameter int COMPONENT_BITS = 32);
	logic                             valid;
	logic                             ready;
	logic signed [COMPONENT_BITS-1:0] a_scalar;
	logic signed [COMPONENT_BITS-1:0] a_vec_x;
	logic signed [COMPONENT_BITS-1:0] a_vec_y;
	logic signed [COMPONENT_BITS-1:0] a_vec_z;
	logic signed [COMPONENT_BITS-1:0] b_scalar;
	logic signed [COMPONENT_BITS-1:0] b_vec_x;
	logic signed [COMPONENT_BITS-1:0] b_vec_y;
	logic signed [COMPONENT_BITS-1:0] b_vec_z;

	modport source (
		output valid, a_scalar, a_vec_x, a_vec_y, a_vec_z,
		output b_scalar, b_vec_x, b_vec_y, b_vec_z,
		input  ready
	);
	modport sink (
		input  valid, a_scalar, a_vec_x, a_vec_y, a_vec_z,
		input  b_scalar, b_vec_x, b_vec_y, b_vec_z,
		output ready
	);
endinterface

>>> rtl/qmn_out_if.sv
// Result channel of the normalized quaternion product block.
// Carries valid, ready, the unit quaternion and the zero flag; no dependencies.
interface qmn_out_if #(parameter int COMPONENT_BITS = 32);
	logic                             valid;
	logic                             ready;
	logic signed [COMPONENT_BITS-1:0] out_scalar;
	logic signed [COMPONENT_BITS-1:0] out_vec_x;
	logic signed [COMPONENT_BITS-1:0] out_vec_y;
	logic signed [COMPONENT_BITS-1:0] out_vec_z;
	logic                             zero_norm;

	modport source (
		output valid, out_scalar, out_vec_x, out_vec_y, out_vec_z, zero_norm,
		input  ready
	);
	modport sink (
		input  valid, out_scalar, out_vec_x, out_vec_y, out_vec_z, zero_norm,
		output ready
	);
endinterface

>>> rtl/qmn_root_step.sv
// One registered step of the digit recurrence that finds floor(2*|r_k|*2^F/|r|).
// Handles all four components in parallel; depends on qmn_pkg.
module qmn_root_step #(
	parameter int EW = 166,
	parameter int QW = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  qmn_pkg::side_t    side_in,
	input  logic [EW-1:0]     s_in,
	input  logic [EW-1:0]     s3_in,
	input  logic [EW-1:0]     e_in [4],
	input  logic [EW-1:0]     w_in [4],
	input  logic [QW-1:0]     q_in [4],
	output qmn_pkg::side_t    side_out,
	output logic [EW-1:0]     s_out,
	output logic [EW-1:0]     s3_out,
	output logic [EW-1:0]     e_out [4],
	output logic [EW-1:0]     w_out [4],
	output logic [QW-1:0]     q_out [4]
);

	logic [EW:0]   diff_c [4];
	logic          dig_c  [4];
	logic [EW-1:0] keep_c [4];
	logic [EW-1:0] e_c    [4];
	logic [EW-1:0] w_c    [4];
	logic [QW-1:0] q_c    [4];

	qmn_pkg::side_t side_q;
	logic [EW-1:0]  s_q;
	logic [EW-1:0]  s3_q;
	logic [EW-1:0]  e_q [4];
	logic [EW-1:0]  w_q [4];
	logic [QW-1:0]  q_q [4];

	// Trial subtraction of the residual; the next digit is one when it does not borrow.
	// The bound W tracks 4*Q*S + S, so it moves to 2W+3S or 2W-S with the digit.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			diff_c[k] = {1'b0, e_in[k]} - {1'b0, w_in[k]};
			dig_c[k]  = ~diff_c[k][EW];
			keep_c[k] = dig_c[k] ? diff_c[k][EW-1:0] : e_in[k];
			e_c[k]    = keep_c[k] << 2;
			w_c[k]    = dig_c[k] ? ((w_in[k] << 1) + s3_in) : ((w_in[k] << 1) - s_in);
			q_c[k]    = {q_in[k][QW-2:0], dig_c[k]};
		end
	end

	// Side-band register, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else if (en) begin
			side_q <= side_in;
		end
	end

	// Data registers of the step.
	always_ff @(posedge clk) begin
		if (en) begin
			s_q  <= s_in;
			s3_q <= s3_in;
			for (int k = 0; k < 4; k++) begin
				e_q[k] <= e_c[k];
				w_q[k] <= w_c[k];
				q_q[k] <= q_c[k];
			end
		end
	end

	assign side_out = side_q;
	assign s_out    = s_q;
	assign s3_out   = s3_q;
	assign e_out    = e_q;
	assign w_out    = w_q;
	assign q_out    = q_q;

endmodule

>>> rtl/quaternion_multiply_normalize.sv
// Top level of the normalized Hamilton quaternion product.
// Depends on qmn_pkg, qmn_in_if, qmn_out_if and qmn_root_step.
//
// Usage: the operands channel takes two scalar-first quaternions in signed
// fixed point (COMPONENT_BITS wide, FRACTION_BITS fraction bits). The result
// channel returns the product divided by its norm, rounded to nearest with
// ties away from zero, plus zero_norm, which is set (with all components zero)
// when the product is the zero quaternion.
// An accepted transaction passes through the stages in order: seven stages
// form the products, the component sums, magnitudes, squares and the squared
// norm, then one stage per quotient bit (FRACTION_BITS + 2) runs the digit
// recurrence, and the last stage rounds and drives the output register.
// Throughput is one transaction per cycle unless the receiver stalls; each
// recurrence stage holds its own registers, so no unit is shared between
// transactions. Reset clears every valid bit, so the pipeline comes up empty.
// When the receiver stalls with a result pending, the whole pipeline holds and
// operands.ready drops; nothing is lost or repeated.
module quaternion_multiply_normalize #(
	parameter int COMPONENT_BITS = 32,
	parameter int FRACTION_BITS  = 30
) (
	input logic       clk,
	input logic       arst_n,
	qmn_in_if.sink    operands,
	qmn_out_if.source result
);

	localparam int N    = COMPONENT_BITS;
	localparam int F    = FRACTION_BITS;
	localparam int PW   = 2 * N;
	localparam int RW   = 2 * N + 2;
	localparam int MW   = 2 * N + 1;
	localparam int LW   = N + 1;
	localparam int HW   = MW - LW;
	localparam int EW   = F + 4 * N + 8;
	localparam int QW   = F + 2;
	localparam int NSTG = F + 2;

	logic advance;

	logic signed [N-1:0]  a_in [4];
	logic signed [N-1:0]  b_in [4];
	logic signed [PW-1:0] prod_c [4][4];
	logic signed [RW-1:0] sum_c  [4];
	logic signed [RW-1:0] negr_c [4];
	logic [HW-1:0]        hi_c   [4];
	logic [LW-1:0]        lo_c   [4];
	logic [EW-1:0]        sum_s_c;

	logic                 v_s1;
	logic signed [PW-1:0] prod_s1 [4][4];
	logic                 v_s2;
	logic signed [RW-1:0] r_s2 [4];
	qmn_pkg::side_t       side_s3;
	logic [MW-1:0]        mag_s3 [4];
	qmn_pkg::side_t       side_s4;
	logic [2*HW-1:0]      hh_s4 [4];
	logic [HW+LW-1:0]     hl_s4 [4];
	logic [2*LW-1:0]      ll_s4 [4];
	qmn_pkg::side_t       side_s5;
	logic [EW-1:0]        sq_s5 [4];
	qmn_pkg::side_t       side_s6;
	logic [EW-1:0]        sq_s6 [4];
	logic [EW-1:0]        s_s6;
	qmn_pkg::side_t       side_s7;
	logic [EW-1:0]        e_s7 [4];
	logic [EW-1:0]        s_s7;
	logic [EW-1:0]        s3_s7;

	qmn_pkg::side_t ch_side [NSTG+1];
	logic [EW-1:0]  ch_s    [NSTG+1];
	logic [EW-1:0]  ch_s3   [NSTG+1];
	logic [EW-1:0]  ch_e    [NSTG+1][4];
	logic [EW-1:0]  ch_w    [NSTG+1][4];
	logic [QW-1:0]  ch_q    [NSTG+1][4];

	logic [QW:0]         rnd_c [4];
	logic [N-1:0]        val_c [4];
	logic signed [N-1:0] comp_c [4];

	qmn_pkg::side_t      out_side_q;
	logic signed [N-1:0] out_comp_q [4];

	// The pipeline moves whenever the output register is empty or being taken.
	assign advance        = ~out_side_q.vld | result.ready;
	assign operands.ready = advance;

	assign a_in[0] = operands.a_scalar;
	assign a_in[1] = operands.a_vec_x;
	assign a_in[2] = operands.a_vec_y;
	assign a_in[3] = operands.a_vec_z;
	assign b_in[0] = operands.b_scalar;
	assign b_in[1] = operands.b_vec_x;
	assign b_in[2] = operands.b_vec_y;
	assign b_in[3] = operands.b_vec_z;

	// Stage 1: all sixteen cross products of the components.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				prod_c[i][j] = PW'(a_in[i]) * PW'(b_in[j]);
			end
		end
	end

	// Stage 2: signed sums of four terms give the exact product components.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sum_c[k] = '0;
			for (int t = 0; t < 4; t++) begin
				if (qmn_pkg::TERM_NEG[k][t]) begin
					sum_c[k] = sum_c[k] - RW'(prod_s1[qmn_pkg::TERM_A[k][t]][qmn_pkg::TERM_B[k][t]]);
				end else begin
					sum_c[k] = sum_c[k] + RW'(prod_s1[qmn_pkg::TERM_A[k][t]][qmn_pkg::TERM_B[k][t]]);
				end
			end
		end
	end

	// Stage 3 and 4 helpers: negation for the magnitude, then halves for squaring.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			negr_c[k] = -r_s2[k];
			hi_c[k]   = mag_s3[k][MW-1:LW];
			lo_c[k]   = mag_s3[k][LW-1:0];
		end
	end

	// Stage 6 helper: the squared norm is the sum of the squared components.
	assign sum_s_c = sq_s5[0] + sq_s5[1] + sq_s5[2] + sq_s5[3];

	// Valid and side-band registers of the front stages, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			side_s3 <= '0;
			side_s4 <= '0;
			side_s5 <= '0;
			side_s6 <= '0;
			side_s7 <= '0;
		end else if (advance) begin
			v_s1         <= operands.valid;
			v_s2         <= v_s1;
			side_s3.vld  <= v_s2;
			side_s3.zero <= (r_s2[0] == '0) && (r_s2[1] == '0) &&
				(r_s2[2] == '0) && (r_s2[3] == '0);
			for (int k = 0; k < 4; k++) begin
				side_s3.neg[k] <= r_s2[k][RW-1];
			end
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			side_s6 <= side_s5;
			side_s7 <= side_s6;
		end
	end

	// Data registers of the front stages.
	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s1 <= prod_c;
			r_s2    <= sum_c;
			for (int k = 0; k < 4; k++) begin
				mag_s3[k] <= r_s2[k][RW-1] ? negr_c[k][MW-1:0] : r_s2[k][MW-1:0];
				hh_s4[k]  <= (2*HW)'(hi_c[k]) * (2*HW)'(hi_c[k]);
				hl_s4[k]  <= (HW+LW)'(hi_c[k]) * (HW+LW)'(lo_c[k]);
				ll_s4[k]  <= (2*LW)'(lo_c[k]) * (2*LW)'(lo_c[k]);
				sq_s5[k]  <= (EW'(hh_s4[k]) << (2 * LW)) + (EW'(hl_s4[k]) << (LW + 1)) +
					EW'(ll_s4[k]);
				sq_s6[k]  <= sq_s5[k];
				e_s7[k]   <= sq_s6[k];
			end
			s_s6  <= sum_s_c;
			s_s7  <= s_s6;
			s3_s7 <= s_s6 + (s_s6 << 1);
		end
	end

	// Seed of the recurrence: residual r_k^2, bound S, empty quotient.
	always_comb begin
		ch_side[0] = side_s7;
		ch_s[0]    = s_s7;
		ch_s3[0]   = s3_s7;
		for (int k = 0; k < 4; k++) begin
			ch_e[0][k] = e_s7[k];
			ch_w[0][k] = s_s7;
			ch_q[0][k] = '0;
		end
	end

	// One recurrence stage for each quotient bit, most significant first.
	for (genvar g = 0; g < NSTG; g++) begin : g_root
		qmn_root_step #(
			.EW (EW),
			.QW (QW)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (advance),
			.side_in  (ch_side[g]),
			.s_in     (ch_s[g]),
			.s3_in    (ch_s3[g]),
			.e_in     (ch_e[g]),
			.w_in     (ch_w[g]),
			.q_in     (ch_q[g]),
			.side_out (ch_side[g+1]),
			.s_out    (ch_s[g+1]),
			.s3_out   (ch_s3[g+1]),
			.e_out    (ch_e[g+1]),
			.w_out    (ch_w[g+1]),
			.q_out    (ch_q[g+1])
		);
	end

	// Final rounding: halve the doubled quotient with a carry-in, then restore the sign.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			rnd_c[k] = {1'b0, ch_q[NSTG][k]} + (QW+1)'(1);
			val_c[k] = N'(rnd_c[k][QW:1]);
			if (ch_side[NSTG].zero) begin
				comp_c[k] = '0;
			end else if (ch_side[NSTG].neg[k]) begin
				comp_c[k] = -$signed(val_c[k]);
			end else begin
				comp_c[k] = $signed(val_c[k]);
			end
		end
	end

	// Output register, valid cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_side_q <= '0;
		end else if (advance) begin
			out_side_q <= ch_side[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_comp_q <= comp_c;
		end
	end

	assign result.valid      = out_side_q.vld;
	assign result.zero_norm  = out_side_q.zero;
	assign result.out_scalar = out_comp_q[0];
	assign result.out_vec_x  = out_comp_q[1];
	assign result.out_vec_y  = out_comp_q[2];
	assign result.out_vec_z  = out_comp_q[3];

endmodule

>>> rtl/qmn_checker.sv
// Port-level checks of the normalized quaternion product block, and their bind.
// Depends only on the ports of quaternion_multiply_normalize.
module qmn_checker #(
	parameter int COMPONENT_BITS = 32,
	parameter int FRACTION_BITS  = 30
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [COMPONENT_BITS-1:0] out_scalar,
	input logic signed [COMPONENT_BITS-1:0] out_vec_x,
	input logic signed [COMPONENT_BITS-1:0] out_vec_y,
	input logic signed [COMPONENT_BITS-1:0] out_vec_z,
	input logic                             zero_norm
);

	localparam logic signed [COMPONENT_BITS-1:0] UNIT_POS =
		COMPONENT_BITS'(1) << FRACTION_BITS;
	localparam logic signed [COMPONENT_BITS-1:0] UNIT_NEG = -UNIT_POS;

	// A stalled result stays put until the transaction completes.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_scalar) &&
		$stable(out_vec_x) && $stable(out_vec_y) && $stable(out_vec_z) &&
		$stable(zero_norm))
		else $error("result changed while stalled");

	// A zero product yields the zero quaternion.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_norm |-> out_scalar == '0 && out_vec_x == '0 &&
		out_vec_y == '0 && out_vec_z == '0)
		else $error("zero_norm with nonzero components");

	// Each component of a unit quaternion lies within plus or minus one.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !zero_norm |->
		out_scalar <= UNIT_POS && out_scalar >= UNIT_NEG &&
		out_vec_x <= UNIT_POS && out_vec_x >= UNIT_NEG &&
		out_vec_y <= UNIT_POS && out_vec_y >= UNIT_NEG &&
		out_vec_z <= UNIT_POS && out_vec_z >= UNIT_NEG)
		else $error("component outside the unit range");

	// The operand side only waits while a result is held back by the receiver.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("operands stalled without a result stall");

endmodule

bind quaternion_multiply_normalize qmn_checker #(
	.COMPONENT_BITS (COMPONENT_BITS),
	.FRACTION_BITS  (FRACTION_BITS)
) u_qmn_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (operands.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_scalar (result.out_scalar),
	.out_vec_x  (result.out_vec_x),
	.out_vec_y  (result.out_vec_y),
	.out_vec_z  (result.out_vec_z),
	.zero_norm  (result.zero_norm)
);
